// ----- rtl/wpb_pkg.sv -----
// package for the waveform peak binner
// holds field widths, register reset value and parameter defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wpb_pkg;

  // clip length register
  localparam int unsigned LenW            = 24;
  localparam logic [LenW-1:0] ClipLengthReset = 24'd16000;

  // parameter defaults
  localparam int unsigned BinCountDefault   = 512;
  localparam int unsigned SampleBitsDefault = 16;

endpackage : wpb_pkg

`default_nettype wire

// ----- rtl/waveform_peak_binner.sv -----
// waveform peak binner top level: sample input register, bin tracking, result register
// depends on wpb_pkg
`timescale 1ns / 1ps
`default_nettype none

// Peak envelope of one audio clip. Signed samples arrive one item at a time and
// are split into BIN_COUNT equal bins over a clip of clip_length samples; sample i
// falls in bin floor(i*BIN_COUNT/length). For each bin the block keeps the
// largest magnitude seen (the most negative code saturates to the largest positive
// one) and emits one result item with the bin index, its peak and a last flag when
// the bin ends; after the final bin it rearms for the next clip. A length below
// BIN_COUNT counts as BIN_COUNT. The bin boundary is found with a running
// remainder that grows by BIN_COUNT per sample, so no divider is needed.
// Throughput is one sample per clock: the only loop is the remainder/peak update,
// one add, one subtract and a few compares between the input register and the state
// registers. An accepted sample waits in the input register; the one that ends a bin then writes the result register.
// The input stalls only when a result must be written while the result register
// is still held by a stalled consumer. clip_length may be written only while the
// block is idle.

module waveform_peak_binner #(
  parameter int unsigned BIN_COUNT   = wpb_pkg::BinCountDefault,
  parameter int unsigned SAMPLE_BITS = wpb_pkg::SampleBitsDefault,
  localparam int unsigned BinW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1,
  localparam int unsigned PeakW = SAMPLE_BITS - 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // clip length register
  input  wire logic                          clip_length_we_i,
  input  wire logic [wpb_pkg::LenW-1:0]      clip_length_i,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [BinW-1:0]                    bin_o,
  output logic [PeakW-1:0]                   peak_o,
  output logic                               last_bin_o
);

  localparam int unsigned LenW = wpb_pkg::LenW;
  localparam int unsigned SumW = LenW + 1;
  localparam logic [SumW-1:0] BinStep  = SumW'(BIN_COUNT);
  localparam logic [BinW-1:0] LastBin  = BinW'(BIN_COUNT - 1);
  localparam logic [PeakW-1:0] PeakMax = {PeakW{1'b1}};

  // configuration
  logic [LenW-1:0] clip_length_q;

  // input register
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;

  // binning state
  logic [PeakW-1:0] peak_q,  peak_d;
  logic [BinW-1:0]  bin_q,   bin_d;
  logic [LenW-1:0]  rem_q,   rem_d;

  // result register
  logic             out_valid_q;
  logic [BinW-1:0]  out_bin_q;
  logic [PeakW-1:0] out_peak_q;
  logic             out_last_q;

  // datapath
  logic [SAMPLE_BITS-1:0] mag_full;
  logic [PeakW-1:0]       mag;
  logic [PeakW-1:0]       peak_new;
  logic [SumW-1:0]        len_eff;
  logic [SumW-1:0]        sum;
  logic [SumW-1:0]        sum_sub;
  logic                   bin_end;
  logic                   is_last;
  logic                   out_ready;
  logic                   s1_go;
  logic                   in_take;

  // magnitude with saturation of the most negative code
  always_comb begin
    mag_full = s1_sample_q[SAMPLE_BITS-1] ? (~s1_sample_q + 1'b1) : s1_sample_q;
    if (mag_full[SAMPLE_BITS-1]) begin
      mag = PeakMax;
    end else begin
      mag = mag_full[PeakW-1:0];
    end
    peak_new = (mag > peak_q) ? mag : peak_q;
  end

  // bin boundary from the running remainder
  always_comb begin
    len_eff = (SumW'(clip_length_q) < BinStep) ? BinStep : SumW'(clip_length_q);
    sum     = SumW'(rem_q) + BinStep;
    bin_end = (sum >= len_eff);
    sum_sub = sum - len_eff;
    is_last = (bin_q >= LastBin);
  end

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!bin_end || out_ready);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  // next binning state
  always_comb begin
    peak_d = peak_new;
    bin_d  = bin_q;
    rem_d  = sum[LenW-1:0];
    if (bin_end) begin
      peak_d = '0;
      if (is_last) begin
        bin_d = '0;
        rem_d = '0;
      end else begin
        bin_d = bin_q + 1'b1;
        // length changed mid-clip: restart the remainder
        rem_d = (sum_sub >= len_eff) ? '0 : sum_sub[LenW-1:0];
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_length_q <= wpb_pkg::ClipLengthReset;
      s1_valid_q    <= 1'b0;
      peak_q        <= '0;
      bin_q         <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (clip_length_we_i) begin
        clip_length_q <= clip_length_i;
      end
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        peak_q <= peak_d;
        bin_q  <= bin_d;
        rem_q  <= rem_d;
      end
      if (s1_go && bin_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= sample_i;
    end
    if (s1_go && bin_end) begin
      out_bin_q  <= bin_q;
      out_peak_q <= peak_new;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_o       = out_bin_q;
  assign peak_o      = out_peak_q;
  assign last_bin_o  = out_last_q;

endmodule : waveform_peak_binner

`default_nettype wire

// ----- rtl/wpb_checker.sv -----
// port-level checker for the waveform peak binner, with its bind statement
// depends on wpb_pkg and waveform_peak_binner
`timescale 1ns / 1ps
`default_nettype none

module wpb_checker #(
  parameter int unsigned BIN_COUNT   = wpb_pkg::BinCountDefault,
  parameter int unsigned SAMPLE_BITS = wpb_pkg::SampleBitsDefault,
  localparam int unsigned BinW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1,
  localparam int unsigned PeakW = SAMPLE_BITS - 1
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [BinW-1:0]  bin_o,
  input wire logic [PeakW-1:0] peak_o,
  input wire logic             last_bin_o
);

  localparam logic [BinW-1:0] LastBin = BinW'(BIN_COUNT - 1);

  // bin index the next result item must carry
  logic [BinW-1:0] exp_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bin_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_bin_q <= last_bin_o ? '0 : bin_o + 1'b1;
    end
  end

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_o) && $stable(peak_o)
      && $stable(last_bin_o))
    else $error("stalled result item changed");

  // bins come out in order, restarting after the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bin_o == exp_bin_q)
    else $error("result bin out of sequence");

  // last flag marks exactly the final bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_bin_o == (bin_o == LastBin))
    else $error("last flag does not match bin index");

  // input stalls only behind a held result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

endmodule : wpb_checker

bind waveform_peak_binner wpb_checker #(
  .BIN_COUNT  (BIN_COUNT),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wpb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .bin_o      (bin_o),
  .peak_o     (peak_o),
  .last_bin_o (last_bin_o)
);

`default_nettype wire

// ----- dv/waveform_peak_binner_tb.sv -----
// testbench for the waveform peak binner: directed and random samples over several clip lengths
// a scoreboard class predicts every bin result; depends on wpb_pkg and waveform_peak_binner
`timescale 1ns / 1ps

module waveform_peak_binner_tb;

  localparam int unsigned LenW        = wpb_pkg::LenW;
  localparam int unsigned BinCount    = wpb_pkg::BinCountDefault;
  localparam int unsigned SampleW     = wpb_pkg::SampleBitsDefault;
  localparam int unsigned BinW        = $clog2(BinCount);
  localparam int unsigned PeakW       = SampleW - 1;
  // idle margin after the last owed bin, before a length write
  localparam int unsigned DrainCycles = 8;
  // long consumer hold-off so the block backs up and stalls its input
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned NumDirected = 24;
  // directed items sent under the reset length before the first write
  localparam int unsigned NumPreWrite = 8;

  typedef struct packed {
    logic [BinW-1:0]  bin_idx;
    logic [PeakW-1:0] peak;
    logic             last;
  } bin_result_t;

  // bin-by-bin peak predictor and the queue of bins still owed by the block
  class peak_scoreboard;
    logic [LenW-1:0]  clip_len;
    logic [PeakW-1:0] bin_peak;
    logic [BinW-1:0]  bin_idx;
    logic [LenW-1:0]  remainder;
    bin_result_t      pending_bins[$];
    int               errors;

    function new();
      clip_len  = wpb_pkg::ClipLengthReset;
      bin_peak  = '0;
      bin_idx   = '0;
      remainder = '0;
      errors    = 0;
    endfunction

    function void set_length(logic [LenW-1:0] len);
      clip_len = len;
    endfunction

    // fold one accepted sample into the running peak, close the bin when the remainder wraps
    function void note_sample(logic signed [SampleW-1:0] s);
      logic [LenW:0]      eff_len;
      logic [LenW:0]      sum;
      logic [SampleW-1:0] mag;
      bin_result_t        res;
      mag = s[SampleW-1] ? (~s + 1'b1) : s;
      // most negative code saturates to full scale
      if (mag[SampleW-1]) mag = {1'b0, {PeakW{1'b1}}};
      if (mag[PeakW-1:0] > bin_peak) bin_peak = mag[PeakW-1:0];
      // lengths below the bin count act as the bin count
      eff_len = (clip_len < BinCount) ? (LenW+1)'(BinCount) : {1'b0, clip_len};
      sum = {1'b0, remainder} + (LenW+1)'(BinCount);
      if (sum < eff_len) begin
        remainder = sum[LenW-1:0];
        return;
      end
      sum = sum - eff_len;
      // length shrunk mid-clip: restart the remainder
      if (sum >= eff_len) sum = '0;
      res.bin_idx = bin_idx;
      res.peak    = bin_peak;
      res.last    = (bin_idx == BinCount - 1);
      pending_bins.push_back(res);
      bin_peak = '0;
      if (res.last) begin
        bin_idx   = '0;
        remainder = '0;
      end else begin
        bin_idx   = bin_idx + 1'b1;
        remainder = sum[LenW-1:0];
      end
    endfunction

    function void check_result(bin_result_t got);
      bin_result_t want;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected bin, none pending: bin %0d peak %0d last %0b",
                 $time, got.bin_idx, got.peak, got.last);
        errors++;
        return;
      end
      want = pending_bins.pop_front();
      if (got.bin_idx !== want.bin_idx) begin
        $display("%0t: bin index expected %0d actual %0d", $time, want.bin_idx, got.bin_idx);
        errors++;
      end
      if (got.peak !== want.peak) begin
        $display("%0t: peak of bin %0d expected %0d actual %0d",
                 $time, want.bin_idx, want.peak, got.peak);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last flag of bin %0d expected %0b actual %0b",
                 $time, want.bin_idx, want.last, got.last);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending_bins.size() != 0) begin
        $display("%0t: %0d bins expected but never seen, next bin %0d peak %0d",
                 $time, pending_bins.size(), pending_bins[0].bin_idx, pending_bins[0].peak);
        errors++;
      end
    endfunction
  endclass

  // dut ports; every input that the bench drives is known from time zero
  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      clip_length_we_i = 1'b0;
  logic [LenW-1:0]           clip_length_i    = '0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i         = '0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic [BinW-1:0]           bin_o;
  logic [PeakW-1:0]          peak_o;
  logic                      last_bin_o;

  peak_scoreboard sb = new();

  // random idling on both sides; cleared for the closing phase
  bit idle_on  = 1'b1;
  // asks the stall process for one long hold-off
  bit hold_req = 1'b0;

  // extremes and alternating bit patterns; after the first write each item is its own bin
  logic signed [SampleW-1:0] directed_samples [NumDirected] = '{
    16'sh7fff, 16'sh8000, 16'sh8001, 16'sh0000, 16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa,
    16'sh8000, 16'sh7fff, 16'sh8001, 16'sh0000, 16'shffff, 16'sh0001, 16'sh4000, 16'shc000,
    16'sh5555, 16'shaaaa, 16'sh3fff, 16'shc001, 16'sh0000, 16'sh1234, 16'shedcb, 16'sh8000
  };

  // clip length per phase: short, maximum, exact bin count, random, below the bin count,
  // the reset value and a moderate one; the maximum phase leaves a large remainder so the
  // next, shorter length forces the remainder restart
  logic [LenW-1:0] phase_len [NumPhases] = '{
    24'd700, 24'hffffff, 24'd512, 24'd0, 24'd511, 24'd16000, 24'd1000
  };
  int unsigned phase_items [NumPhases] = '{300, 60, 600, 400, 150, 100, 320};

  waveform_peak_binner dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clip_length_we_i (clip_length_we_i),
    .clip_length_i    (clip_length_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .bin_o            (bin_o),
    .peak_o           (peak_o),
    .last_bin_o       (last_bin_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random sample: mostly full range, with extremes and quiet values mixed in
  function automatic logic signed [SampleW-1:0] pick_sample();
    logic [4:0] quiet;
    quiet = 5'($urandom);
    case ($urandom_range(0, 9))
      0:       return {1'b1, {PeakW{1'b0}}};
      1:       return {1'b0, {PeakW{1'b1}}};
      2:       return {{(SampleW-5){quiet[4]}}, quiet};
      default: return SampleW'($urandom);
    endcase
  endfunction

  // offer one item, optionally after an idle burst, and hold it until accepted
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
  endtask

  // stop offering, let every owed bin arrive, then let the pipe empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LenW-1:0] len);
    wait_idle();
    clip_length_we_i <= 1'b1;
    clip_length_i    <= len;
    @(posedge clk_i);
    clip_length_we_i <= 1'b0;
    sb.set_length(len);
  endtask

  // result monitor: every accepted item is checked against the oldest owed bin
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result({bin_o, peak_o, last_bin_o});
  end

  // consumer stall: random bursts, plus one long hold-off on request
  initial begin : result_stall
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HoldCycles; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few items under the reset length, then a zero length (acts as the bin count),
    // which also restarts the remainder left mid-clip
    for (k = 0; k < NumPreWrite; k++) send_sample(directed_samples[k]);
    write_length('0);
    for (k = NumPreWrite; k < NumDirected; k++) send_sample(directed_samples[k]);

    for (p = 0; p < NumPhases; p++) begin
      if (phase_len[p] == '0) phase_len[p] = LenW'($urandom_range(513, 3000));
      write_length(phase_len[p]);
      // one bin per item here, so the hold-off backs the block up quickly
      if (p == 2) hold_req = 1'b1;
      if (p == NumPhases - 1) idle_on = 1'b0;
      for (k = 0; k < phase_items[p]; k++) send_sample(pick_sample());
    end

    wait_idle();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wpb_pkg.sv
rtl/waveform_peak_binner.sv
rtl/wpb_checker.sv
dv/waveform_peak_binner_tb.sv
